FILE: hw/rtl/dfa_pkg.sv
// dfa_pkg: sizes, request and cause codes, controller state and the
// command and status structs shared by the automaton modules
// no dependencies
package dfa_pkg;

    localparam int STATE_COUNT  = 64;
    localparam int SYMBOL_SLOTS = 16;

    localparam int STATE_W = $clog2(STATE_COUNT);
    localparam int SLOT_W  = $clog2(SYMBOL_SLOTS);
    localparam int COUNT_W = $clog2(SYMBOL_SLOTS + 1);
    localparam int CHAR_W  = 8;
    localparam int MASK_W  = 64;
    localparam int CAUSE_W = 2;
    localparam int REQ_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam int TRANS_DEPTH = STATE_COUNT * SYMBOL_SLOTS;
    localparam int TRANS_AW    = $clog2(TRANS_DEPTH);
    localparam int TRANS_W     = STATE_W + 1;

    localparam logic [REQ_W-1:0] REQ_LOAD_SYMBOL = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_TRANS  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FEED        = 2'd2;
    localparam logic [REQ_W-1:0] REQ_END         = 2'd3;

    localparam logic [CAUSE_W-1:0] CAUSE_NONE     = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_UNKNOWN  = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_NO_TRANS = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_STATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_MASK   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT  = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } ctrl_state_t;

    typedef struct packed {
        logic clear_we;
        logic accept;
        logic lookup;
        logic load_result;
    } dfa_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic need_lookup;
    } dfa_status_t;

endpackage

FILE: hw/rtl/dfa_ram.sv
// dfa_ram: generic single write port, single read port ram with registered read
// no dependencies
module dfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/dfa_ctrl.sv
// dfa_ctrl: controller for the automaton (clearing pass, accept, table lookup,
// result handshake); depends on dfa_pkg
module dfa_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  dfa_pkg::dfa_status_t  status,
    output dfa_pkg::dfa_cmd_t     cmd
);

    dfa_pkg::ctrl_state_t state_reg;
    dfa_pkg::ctrl_state_t state_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dfa_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        in_ready        = 1'b0;
        cmd             = '0;
        out_valid_next  = out_valid_reg && !out_ready;
        case (state_reg)
            dfa_pkg::ST_CLEAR:
            begin
                cmd.clear_we = 1'b1;
                if (status.clear_done)
                begin
                    state_next = dfa_pkg::ST_IDLE;
                end
            end
            dfa_pkg::ST_IDLE:
            begin
                in_ready   = !out_valid_reg || out_ready;
                cmd.accept = in_valid && in_ready;
                if (cmd.accept)
                begin
                    if (status.need_lookup)
                    begin
                        state_next = dfa_pkg::ST_LOOKUP;
                    end
                    else
                    begin
                        cmd.load_result = 1'b1;
                        out_valid_next  = 1'b1;
                    end
                end
            end
            dfa_pkg::ST_LOOKUP:
            begin
                cmd.lookup      = 1'b1;
                cmd.load_result = 1'b1;
                out_valid_next  = 1'b1;
                state_next      = dfa_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dfa_pkg::ST_CLEAR;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: hw/rtl/dfa_datapath.sv
// dfa_datapath: configuration, symbol table, transition ram, automaton state
// and result registers; depends on dfa_pkg and dfa_ram
module dfa_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dfa_pkg::dfa_cmd_t                 cmd,
    output dfa_pkg::dfa_status_t              status,
    input  logic                              cfg_we,
    input  logic [dfa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dfa_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [dfa_pkg::REQ_W-1:0]         req_type,
    input  logic [dfa_pkg::SLOT_W-1:0]        slot,
    input  logic [dfa_pkg::STATE_W-1:0]       from_state,
    input  logic [dfa_pkg::STATE_W-1:0]       next_state,
    input  logic                              has_next,
    input  logic [dfa_pkg::CHAR_W-1:0]        char_value,
    output logic                              accepted,
    output logic                              failed,
    output logic [dfa_pkg::CAUSE_W-1:0]       fail_cause,
    output logic [dfa_pkg::STATE_W-1:0]       state_now
);

    logic [dfa_pkg::STATE_W-1:0]  initial_state_reg;
    logic [dfa_pkg::MASK_W-1:0]   accept_mask_reg;
    logic [dfa_pkg::COUNT_W-1:0]  symbol_count_reg;

    logic [dfa_pkg::CHAR_W-1:0]   sym_reg [dfa_pkg::SYMBOL_SLOTS];

    logic [dfa_pkg::STATE_W-1:0]  cur_state_reg;
    logic [dfa_pkg::STATE_W-1:0]  cur_state_next;
    logic                         latch_reg;
    logic                         latch_next;
    logic [dfa_pkg::CAUSE_W-1:0]  cause_reg;
    logic [dfa_pkg::CAUSE_W-1:0]  cause_next;

    logic [dfa_pkg::TRANS_AW-1:0] clr_cnt_reg;

    logic                         accepted_reg;
    logic                         accepted_next;
    logic                         failed_reg;
    logic [dfa_pkg::CAUSE_W-1:0]  fail_cause_reg;
    logic [dfa_pkg::STATE_W-1:0]  state_now_reg;

    logic [dfa_pkg::COUNT_W-1:0]  used;
    logic                         found;
    logic [dfa_pkg::SLOT_W-1:0]   hit;

    logic                         ram_we;
    logic [dfa_pkg::TRANS_AW-1:0] ram_waddr;
    logic [dfa_pkg::TRANS_W-1:0]  ram_wdata;
    logic [dfa_pkg::TRANS_AW-1:0] ram_raddr;
    logic [dfa_pkg::TRANS_W-1:0]  ram_rdata;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_state_reg <= '0;
            accept_mask_reg   <= '0;
            symbol_count_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dfa_pkg::CFG_INITIAL_STATE:
                    initial_state_reg <= cfg_data[dfa_pkg::STATE_W-1:0];
                dfa_pkg::CFG_ACCEPT_MASK:
                    accept_mask_reg <= cfg_data[dfa_pkg::MASK_W-1:0];
                dfa_pkg::CFG_SYMBOL_COUNT:
                    symbol_count_reg <= cfg_data[dfa_pkg::COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // symbol match: lowest slot below the clamped count
    always_comb
    begin
        used  = (symbol_count_reg > dfa_pkg::COUNT_W'(dfa_pkg::SYMBOL_SLOTS)) ?
                dfa_pkg::COUNT_W'(dfa_pkg::SYMBOL_SLOTS) : symbol_count_reg;
        found = 1'b0;
        hit   = '0;
        for (int j = dfa_pkg::SYMBOL_SLOTS - 1; j >= 0; j--)
        begin
            if ((sym_reg[j] == char_value) && (dfa_pkg::COUNT_W'(j) < used))
            begin
                found = 1'b1;
                hit   = dfa_pkg::SLOT_W'(j);
            end
        end
    end

    assign status.need_lookup = (req_type == dfa_pkg::REQ_FEED) && !latch_reg && found;
    assign status.clear_done  = (clr_cnt_reg == '1);

    // transition ram
    always_comb
    begin
        ram_raddr = {cur_state_reg, hit};
        if (cmd.clear_we)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = cmd.accept && (req_type == dfa_pkg::REQ_LOAD_TRANS);
            ram_waddr = {from_state, slot};
            ram_wdata = {has_next, next_state};
        end
    end

    dfa_ram #(
        .WIDTH (dfa_pkg::TRANS_W),
        .DEPTH (dfa_pkg::TRANS_DEPTH)
    ) u_trans_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // automaton state and result
    always_comb
    begin
        cur_state_next = cur_state_reg;
        latch_next     = latch_reg;
        cause_next     = cause_reg;
        accepted_next  = 1'b0;
        if (cmd.lookup)
        begin
            if (ram_rdata[dfa_pkg::STATE_W])
            begin
                cur_state_next = ram_rdata[dfa_pkg::STATE_W-1:0];
            end
            else
            begin
                latch_next = 1'b1;
                cause_next = dfa_pkg::CAUSE_NO_TRANS;
            end
        end
        else if (cmd.accept)
        begin
            case (req_type)
                dfa_pkg::REQ_FEED:
                begin
                    if (!latch_reg && !found)
                    begin
                        latch_next = 1'b1;
                        cause_next = dfa_pkg::CAUSE_UNKNOWN;
                    end
                end
                dfa_pkg::REQ_END:
                begin
                    accepted_next  = !latch_reg && accept_mask_reg[cur_state_reg];
                    cur_state_next = initial_state_reg;
                    latch_next     = 1'b0;
                    cause_next     = dfa_pkg::CAUSE_NONE;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_state_reg <= '0;
            latch_reg     <= 1'b0;
            cause_reg     <= dfa_pkg::CAUSE_NONE;
            clr_cnt_reg   <= '0;
            for (int j = 0; j < dfa_pkg::SYMBOL_SLOTS; j++)
            begin
                sym_reg[j] <= '0;
            end
        end
        else
        begin
            cur_state_reg <= cur_state_next;
            latch_reg     <= latch_next;
            cause_reg     <= cause_next;
            if (cmd.clear_we)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.accept && (req_type == dfa_pkg::REQ_LOAD_SYMBOL))
            begin
                sym_reg[slot] <= char_value;
            end
        end
    end

    // on end of string the flags describe the string that just ended
    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            accepted_reg   <= accepted_next;
            failed_reg     <= cmd.accept && (req_type == dfa_pkg::REQ_END) ?
                              latch_reg : latch_next;
            fail_cause_reg <= cmd.accept && (req_type == dfa_pkg::REQ_END) ?
                              cause_reg : cause_next;
            state_now_reg  <= cur_state_next;
        end
    end

    assign accepted   = accepted_reg;
    assign failed     = failed_reg;
    assign fail_cause = fail_cause_reg;
    assign state_now  = state_now_reg;

endmodule

FILE: hw/rtl/table_driven_dfa_acceptor.sv
// table_driven_dfa_acceptor: top level, controller plus datapath
// depends on dfa_pkg, dfa_ctrl, dfa_datapath
//
//   channel   handshake             payload
//   cfg       cfg_we                cfg_index, cfg_data
//   in        in_valid / in_ready   req_type, slot, from_state, next_state,
//                                   has_next, char_value
//   out       out_valid / out_ready accepted, failed, fail_cause, state_now
//
// feed transactions that reach the table pass through the lookup state (registered
// ram read), every other transaction loads its result at once; one transaction in flight at a time
// after reset a clearing pass over all 1024 entries empties the transition ram,
// in_ready stays low meanwhile; configuration writes are taken throughout
// a result held in the output register is dropped when taken, and a new
// transaction is taken in that same cycle
module table_driven_dfa_acceptor (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dfa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dfa_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [dfa_pkg::REQ_W-1:0]         req_type,
    input  logic [dfa_pkg::SLOT_W-1:0]        slot,
    input  logic [dfa_pkg::STATE_W-1:0]       from_state,
    input  logic [dfa_pkg::STATE_W-1:0]       next_state,
    input  logic                              has_next,
    input  logic [dfa_pkg::CHAR_W-1:0]        char_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              accepted,
    output logic                              failed,
    output logic [dfa_pkg::CAUSE_W-1:0]       fail_cause,
    output logic [dfa_pkg::STATE_W-1:0]       state_now
);

    dfa_pkg::dfa_cmd_t    cmd;
    dfa_pkg::dfa_status_t status;

    dfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    dfa_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_type   (req_type),
        .slot       (slot),
        .from_state (from_state),
        .next_state (next_state),
        .has_next   (has_next),
        .char_value (char_value),
        .accepted   (accepted),
        .failed     (failed),
        .fail_cause (fail_cause),
        .state_now  (state_now)
    );

endmodule

FILE: bench/tb_table_driven_dfa_acceptor.sv
// testbench for table_driven_dfa_acceptor: directed and random request streams,
// results checked against a scoreboard class that runs its own automaton
// depends on dfa_pkg and the table_driven_dfa_acceptor rtl
module tb_table_driven_dfa_acceptor;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int ITEM_TARGET    = 1300;

    typedef struct packed {
        logic [dfa_pkg::REQ_W-1:0]   req;
        logic [dfa_pkg::SLOT_W-1:0]  slot;
        logic [dfa_pkg::STATE_W-1:0] src;
        logic [dfa_pkg::STATE_W-1:0] dst;
        logic                        has;
        logic [dfa_pkg::CHAR_W-1:0]  ch;
    } dfa_item_t;

    typedef struct packed {
        logic                        acc;
        logic                        fail;
        logic [dfa_pkg::CAUSE_W-1:0] cause;
        logic [dfa_pkg::STATE_W-1:0] st;
    } verdict_t;

    class acceptor_scoreboard;
        logic [dfa_pkg::STATE_W-1:0] init_state;
        logic [dfa_pkg::MASK_W-1:0]  accept_bits;
        logic [dfa_pkg::COUNT_W-1:0] sym_count;
        logic [dfa_pkg::STATE_W-1:0] cur_state;
        logic                        rejected;
        logic [dfa_pkg::CAUSE_W-1:0] cause;
        logic [dfa_pkg::CHAR_W-1:0]  sym_tab[dfa_pkg::SYMBOL_SLOTS];
        logic                        trans_ok[dfa_pkg::TRANS_DEPTH];
        logic [dfa_pkg::STATE_W-1:0] trans_tgt[dfa_pkg::TRANS_DEPTH];
        verdict_t                    verdicts_due[$];
        int                          errors;

        function new();
            init_state  = '0;
            accept_bits = '0;
            sym_count   = '0;
            cur_state   = '0;
            rejected    = 1'b0;
            cause       = dfa_pkg::CAUSE_NONE;
            errors      = 0;
            foreach (sym_tab[i]) sym_tab[i] = '0;
            foreach (trans_ok[i])
            begin
                trans_ok[i]  = 1'b0;
                trans_tgt[i] = '0;
            end
        endfunction

        function void write_reg(logic [dfa_pkg::CFG_IDX_W-1:0] idx,
                                logic [dfa_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                dfa_pkg::CFG_INITIAL_STATE: init_state  = data[dfa_pkg::STATE_W-1:0];
                dfa_pkg::CFG_ACCEPT_MASK:   accept_bits = data[dfa_pkg::MASK_W-1:0];
                dfa_pkg::CFG_SYMBOL_COUNT:  sym_count   = data[dfa_pkg::COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function void advance_automaton(logic [dfa_pkg::CHAR_W-1:0] ch);
            int used;
            int hit;
            logic [dfa_pkg::TRANS_AW-1:0] idx;
            hit = -1;
            if (rejected)
                return;
            used = (sym_count > dfa_pkg::SYMBOL_SLOTS) ? dfa_pkg::SYMBOL_SLOTS :
                   int'(sym_count);
            for (int j = 0; j < used; j++)
            begin
                if (hit < 0 && sym_tab[j] == ch)
                    hit = j;
            end
            if (hit < 0)
            begin
                rejected = 1'b1;
                cause    = dfa_pkg::CAUSE_UNKNOWN;
                return;
            end
            idx = {cur_state, hit[dfa_pkg::SLOT_W-1:0]};
            if (!trans_ok[idx])
            begin
                rejected = 1'b1;
                cause    = dfa_pkg::CAUSE_NO_TRANS;
                return;
            end
            cur_state = trans_tgt[idx];
        endfunction

        function void note_input(dfa_item_t it);
            verdict_t v;
            v.acc = 1'b0;
            case (it.req)
                dfa_pkg::REQ_LOAD_SYMBOL: sym_tab[it.slot] = it.ch;
                dfa_pkg::REQ_LOAD_TRANS:
                begin
                    trans_ok[{it.src, it.slot}]  = it.has;
                    trans_tgt[{it.src, it.slot}] = it.dst;
                end
                dfa_pkg::REQ_FEED: advance_automaton(it.ch);
                default: ;
            endcase
            v.fail  = rejected;
            v.cause = cause;
            if (it.req == dfa_pkg::REQ_END)
            begin
                if (!rejected)
                    v.acc = accept_bits[cur_state];
                cur_state = init_state;
                rejected  = 1'b0;
                cause     = dfa_pkg::CAUSE_NONE;
            end
            v.st = cur_state;
            verdicts_due.push_back(v);
        endfunction

        function void check_result(logic acc, logic fail, logic [dfa_pkg::CAUSE_W-1:0] cs,
                                   logic [dfa_pkg::STATE_W-1:0] st);
            verdict_t e;
            if (verdicts_due.size() == 0)
            begin
                $error("result with no transaction pending");
                errors++;
                return;
            end
            e = verdicts_due.pop_front();
            if (acc !== e.acc)
            begin
                $error("accepted: expected %0d, actual %0d", e.acc, acc);
                errors++;
            end
            if (fail !== e.fail)
            begin
                $error("failed: expected %0d, actual %0d", e.fail, fail);
                errors++;
            end
            if (cs !== e.cause)
            begin
                $error("fail_cause: expected %0d, actual %0d", e.cause, cs);
                errors++;
            end
            if (st !== e.st)
            begin
                $error("state_now: expected %0d, actual %0d", e.st, st);
                errors++;
            end
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_we = 1'b0;
    logic [dfa_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [dfa_pkg::CFG_DATA_W-1:0]    cfg_data = '0;
    logic                              in_valid = 1'b0;
    logic                              in_ready;
    logic [dfa_pkg::REQ_W-1:0]         req_type = '0;
    logic [dfa_pkg::SLOT_W-1:0]        slot = '0;
    logic [dfa_pkg::STATE_W-1:0]       from_state = '0;
    logic [dfa_pkg::STATE_W-1:0]       next_state = '0;
    logic                              has_next = 1'b0;
    logic [dfa_pkg::CHAR_W-1:0]        char_value = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic                              accepted;
    logic                              failed;
    logic [dfa_pkg::CAUSE_W-1:0]       fail_cause;
    logic [dfa_pkg::STATE_W-1:0]       state_now;

    acceptor_scoreboard sb = new();

    int tx_idle_pct = 25;
    int rx_idle_pct = 63;
    int items_sent  = 0;
    int hold_left   = 0;
    int quiet_cycles = 0;
    logic hold_req  = 1'b0;

    table_driven_dfa_acceptor u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .slot       (slot),
        .from_state (from_state),
        .next_state (next_state),
        .has_next   (has_next),
        .char_value (char_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .accepted   (accepted),
        .failed     (failed),
        .fail_cause (fail_cause),
        .state_now  (state_now)
    );

    always #10 clk = ~clk;

    // receiver side: random stalls, plus a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready = 1'b0;
        end
        else
        begin
            out_ready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(accepted, failed, fail_cause, state_now);
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic dfa_item_t mk(logic [dfa_pkg::REQ_W-1:0] rq,
                                     logic [dfa_pkg::SLOT_W-1:0] sl,
                                     logic [dfa_pkg::STATE_W-1:0] sr,
                                     logic [dfa_pkg::STATE_W-1:0] ds,
                                     logic hs, logic [dfa_pkg::CHAR_W-1:0] c);
        dfa_item_t it;
        it.req  = rq;
        it.slot = sl;
        it.src  = sr;
        it.dst  = ds;
        it.has  = hs;
        it.ch   = c;
        return it;
    endfunction

    // random item of the given request kind, character given
    function automatic dfa_item_t rand_item(logic [dfa_pkg::REQ_W-1:0] rq,
                                            logic [dfa_pkg::CHAR_W-1:0] c);
        return mk(rq, dfa_pkg::SLOT_W'($urandom), dfa_pkg::STATE_W'($urandom),
                  dfa_pkg::STATE_W'($urandom), 1'($urandom), c);
    endfunction

    function automatic dfa_item_t noise_item();
        return rand_item(dfa_pkg::REQ_W'($urandom), dfa_pkg::CHAR_W'($urandom));
    endfunction

    task automatic send_item(dfa_item_t it);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        req_type   = it.req;
        slot       = it.slot;
        from_state = it.src;
        next_state = it.dst;
        has_next   = it.has;
        char_value = it.ch;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_input(it);
        items_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(logic [dfa_pkg::CFG_IDX_W-1:0] idx,
                                  logic [dfa_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        in_valid  = 1'b0;
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;
        cfg_index = dfa_pkg::CFG_IDX_W'($urandom);
        cfg_data  = {$urandom, $urandom};
        sb.write_reg(idx, data);
    endtask

    initial
    begin
        int phase;
        int used;
        int len;
        int r;
        logic [dfa_pkg::STATE_W-1:0]    pool[4];
        logic [dfa_pkg::CHAR_W-1:0]     alpha[dfa_pkg::SYMBOL_SLOTS];
        logic [dfa_pkg::CFG_DATA_W-1:0] cfg_word;
        logic [dfa_pkg::COUNT_W-1:0]    count_sel;
        logic [dfa_pkg::MASK_W-1:0]     mask_sel;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // directed part
        write_register(dfa_pkg::CFG_INITIAL_STATE, 64'd5);
        write_register(dfa_pkg::CFG_ACCEPT_MASK, 64'h8000_0000_0000_0000);
        write_register(dfa_pkg::CFG_SYMBOL_COUNT, 64'd31);
        send_item(mk(dfa_pkg::REQ_END, 4'd0, 6'd0, 6'd0, 1'b0, 8'h00));
        send_item(mk(dfa_pkg::REQ_LOAD_SYMBOL, 4'd0, 6'd0, 6'd0, 1'b0, 8'h41));
        send_item(mk(dfa_pkg::REQ_LOAD_SYMBOL, 4'd15, 6'd63, 6'd63, 1'b1, 8'hFF));
        send_item(mk(dfa_pkg::REQ_LOAD_SYMBOL, 4'd1, 6'd0, 6'd0, 1'b0, 8'h41));
        send_item(mk(dfa_pkg::REQ_LOAD_TRANS, 4'd0, 6'd5, 6'd63, 1'b1, 8'h00));
        send_item(mk(dfa_pkg::REQ_LOAD_TRANS, 4'd15, 6'd63, 6'd5, 1'b1, 8'hFF));
        send_item(mk(dfa_pkg::REQ_FEED, 4'd0, 6'd0, 6'd0, 1'b0, 8'h41));
        send_item(mk(dfa_pkg::REQ_FEED, 4'd15, 6'd63, 6'd63, 1'b1, 8'hFF));
        send_item(mk(dfa_pkg::REQ_FEED, 4'd0, 6'd0, 6'd0, 1'b0, 8'h41));
        send_item(mk(dfa_pkg::REQ_END, 4'd15, 6'd63, 6'd63, 1'b1, 8'hFF));
        // missing transition, then a feed after the reject
        send_item(mk(dfa_pkg::REQ_FEED, 4'd0, 6'd0, 6'd0, 1'b0, 8'h00));
        send_item(mk(dfa_pkg::REQ_FEED, 4'd0, 6'd0, 6'd0, 1'b0, 8'h41));
        send_item(mk(dfa_pkg::REQ_END, 4'd0, 6'd0, 6'd0, 1'b0, 8'h00));
        // unknown symbol keeps its cause
        send_item(mk(dfa_pkg::REQ_FEED, 4'd0, 6'd0, 6'd0, 1'b0, 8'h99));
        send_item(mk(dfa_pkg::REQ_FEED, 4'd0, 6'd0, 6'd0, 1'b0, 8'h00));
        send_item(mk(dfa_pkg::REQ_END, 4'd0, 6'd0, 6'd0, 1'b0, 8'h00));
        // table load in the middle of a string
        send_item(mk(dfa_pkg::REQ_FEED, 4'd0, 6'd0, 6'd0, 1'b0, 8'h41));
        send_item(mk(dfa_pkg::REQ_LOAD_TRANS, 4'd15, 6'd63, 6'd0, 1'b0, 8'h00));
        send_item(mk(dfa_pkg::REQ_FEED, 4'd0, 6'd0, 6'd0, 1'b0, 8'hFF));
        send_item(mk(dfa_pkg::REQ_END, 4'd0, 6'd0, 6'd0, 1'b0, 8'h00));
        drain_results();
        write_register(dfa_pkg::CFG_SYMBOL_COUNT, 64'd0);
        send_item(mk(dfa_pkg::REQ_FEED, 4'd0, 6'd0, 6'd0, 1'b0, 8'h41));
        send_item(mk(dfa_pkg::REQ_END, 4'd0, 6'd0, 6'd0, 1'b0, 8'h00));
        send_item(mk(dfa_pkg::REQ_LOAD_TRANS, 4'd0, 6'd0, 6'd0, 1'b0, 8'h00));
        send_item(mk(dfa_pkg::REQ_LOAD_SYMBOL, 4'd0, 6'd0, 6'd0, 1'b0, 8'h00));

        // random part, one automaton per phase
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent < ITEM_TARGET / 3)
            begin
                tx_idle_pct = 25;
                rx_idle_pct = 63;
            end
            else if (items_sent < 2 * ITEM_TARGET / 3)
            begin
                tx_idle_pct = 63;
                rx_idle_pct = 25;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            drain_results();

            foreach (pool[k]) pool[k] = dfa_pkg::STATE_W'($urandom);
            mask_sel  = {$urandom, $urandom};
            count_sel = dfa_pkg::COUNT_W'($urandom_range(31));
            case (phase % 5)
                0:
                begin
                    pool[0]   = '1;
                    mask_sel  = '1;
                    count_sel = 5'd16;
                end
                1:
                begin
                    pool[0]   = '0;
                    mask_sel  = '0;
                    count_sel = 5'd31;
                end
                2: count_sel = 5'd0;
                default: ;
            endcase
            cfg_word = {$urandom, $urandom};
            cfg_word[dfa_pkg::STATE_W-1:0] = pool[0];
            write_register(dfa_pkg::CFG_INITIAL_STATE, cfg_word);
            write_register(dfa_pkg::CFG_ACCEPT_MASK, mask_sel);
            cfg_word = {$urandom, $urandom};
            cfg_word[dfa_pkg::COUNT_W-1:0] = count_sel;
            write_register(dfa_pkg::CFG_SYMBOL_COUNT, cfg_word);
            used = (count_sel > dfa_pkg::SYMBOL_SLOTS) ? dfa_pkg::SYMBOL_SLOTS :
                   int'(count_sel);

            // stall the output for a long stretch; the next transaction waits on in_ready meanwhile
            if (phase == 3)
                hold_req = 1'b1;

            send_item(rand_item(dfa_pkg::REQ_END, dfa_pkg::CHAR_W'($urandom)));
            for (int s = 0; s < dfa_pkg::SYMBOL_SLOTS; s++)
            begin
                alpha[s] = dfa_pkg::CHAR_W'($urandom);
                send_item(mk(dfa_pkg::REQ_LOAD_SYMBOL, dfa_pkg::SLOT_W'(s),
                             dfa_pkg::STATE_W'($urandom), dfa_pkg::STATE_W'($urandom),
                             1'($urandom), alpha[s]));
            end
            for (int p = 0; p < 4; p++)
            begin
                for (int s = 0; s < used; s++)
                    send_item(mk(dfa_pkg::REQ_LOAD_TRANS, dfa_pkg::SLOT_W'(s), pool[p],
                                 pool[$urandom_range(3)], ($urandom_range(9) != 0),
                                 dfa_pkg::CHAR_W'($urandom)));
            end

            for (int n = 0; n < 14; n++)
            begin
                len = $urandom_range(10);
                for (int c = 0; c < len; c++)
                begin
                    r = $urandom_range(99);
                    if (r < 85 && used > 0)
                        send_item(rand_item(dfa_pkg::REQ_FEED,
                                            alpha[$urandom_range(used - 1)]));
                    else if (r < 93)
                        send_item(rand_item(dfa_pkg::REQ_FEED,
                                            dfa_pkg::CHAR_W'($urandom)));
                    else
                        send_item(noise_item());
                end
                send_item(rand_item(dfa_pkg::REQ_END, dfa_pkg::CHAR_W'($urandom)));
            end
            phase++;
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
